// ----- design/tdpt_pkg.sv -----
// Shared widths and controller/datapath interface types for the trial division prime test.
package tdpt_pkg;

    localparam int VALUE_BITS = 31;
    // Divisor never exceeds sqrt(2^VALUE_BITS) + 2
    localparam int D_BITS     = (VALUE_BITS + 1) / 2 + 2;
    localparam int SQ_BITS    = 2 * D_BITS;
    localparam int R_BITS     = D_BITS + 1;
    localparam int CNT_BITS   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_div;
        logic publish;
        logic verdict;
    } t_cmd;

    typedef struct packed {
        logic trivial;
        logic trivial_prime;
        logic bound_over;
        logic bit_last;
        logic rem_next_zero;
    } t_status;

endpackage

// ----- design/tdpt_dpath.sv -----
// Datapath: candidate, divisor and square trackers, bit-serial remainder unit, result register.
module tdpt_dpath (
    input  logic                                i_clk,
    input  logic [tdpt_pkg::VALUE_BITS-1:0]     i_candidate,
    input  tdpt_pkg::t_cmd                      i_cmd,
    output tdpt_pkg::t_status                   o_status,
    output logic                                o_is_prime
);

    logic [tdpt_pkg::VALUE_BITS-1:0] r_n;
    logic [tdpt_pkg::D_BITS-1:0]     r_d;
    logic [tdpt_pkg::SQ_BITS-1:0]    r_sq;
    logic [tdpt_pkg::D_BITS-1:0]     r_rem;
    logic [tdpt_pkg::CNT_BITS-1:0]   r_cnt;
    logic                            r_out;

    logic [tdpt_pkg::R_BITS-1:0]     n_rem;
    logic [tdpt_pkg::R_BITS-1:0]     rem_shift;
    logic [tdpt_pkg::R_BITS-1:0]     d_ext;
    logic [tdpt_pkg::SQ_BITS-1:0]    n_ext;
    logic [tdpt_pkg::SQ_BITS-1:0]    sq_inc;

    assign rem_shift = {r_rem, r_n[r_cnt]};
    assign d_ext     = {1'b0, r_d};
    assign n_rem     = (rem_shift >= d_ext) ? (rem_shift - d_ext) : rem_shift;
    assign n_ext     = {{(tdpt_pkg::SQ_BITS-tdpt_pkg::VALUE_BITS){1'b0}}, r_n};
    // (d+2)^2 = d^2 + 4d + 4
    assign sq_inc    = {{(tdpt_pkg::SQ_BITS-tdpt_pkg::D_BITS-2){1'b0}}, r_d, 2'b00}
                       + tdpt_pkg::SQ_BITS'(4);

    always_comb begin
        o_status.trivial       = (r_n < tdpt_pkg::VALUE_BITS'(2)) || !r_n[0]
                                 || (r_n == tdpt_pkg::VALUE_BITS'(2));
        o_status.trivial_prime = (r_n == tdpt_pkg::VALUE_BITS'(2));
        o_status.bound_over    = (r_sq > n_ext);
        o_status.bit_last      = (r_cnt == '0);
        o_status.rem_next_zero = (n_rem == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n  <= i_candidate;
            r_d  <= tdpt_pkg::D_BITS'(3);
            r_sq <= tdpt_pkg::SQ_BITS'(9);
        end
        if (i_cmd.next_div) begin
            r_d  <= r_d + tdpt_pkg::D_BITS'(2);
            r_sq <= r_sq + sq_inc;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_cnt <= tdpt_pkg::CNT_BITS'(tdpt_pkg::VALUE_BITS - 1);
        end
        if (i_cmd.div_step) begin
            // remainder stays below the divisor, so the top bit is always clear
            r_rem <= n_rem[tdpt_pkg::D_BITS-1:0];
            r_cnt <= r_cnt - tdpt_pkg::CNT_BITS'(1);
        end
        if (i_cmd.publish) begin
            r_out <= i_cmd.verdict;
        end
    end

    assign o_is_prime = r_out;

endmodule

// ----- design/tdpt_ctrl.sv -----
// Controller: sequences the bound test and remainder passes and owns both handshakes.
module tdpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tdpt_pkg::t_status i_status,
    output tdpt_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TEST = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_verdict, n_verdict;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    // no item is taken while reset is held
    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_verdict = r_verdict;
        o_cmd     = '0;
        o_cmd.verdict = r_verdict;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                priority if (i_status.trivial) begin
                    n_verdict = i_status.trivial_prime;
                    n_state   = S_DONE;
                end else if (i_status.bound_over) begin
                    n_verdict = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.bit_last) begin
                    if (i_status.rem_next_zero) begin
                        n_verdict = 1'b0;
                        n_state   = S_DONE;
                    end else begin
                        o_cmd.next_div = 1'b1;
                        n_state        = S_TEST;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_verdict <= n_verdict;
    end

    assign o_out_valid = r_out_valid;

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> (!r_out_valid || i_out_ready))
        else $error("result published over an untaken item");

    a_accept_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_TEST))
        else $error("accepted item did not start testing");

    a_div_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.bit_last && !i_status.rem_next_zero)
        |=> (r_state == S_TEST))
        else $error("non-zero remainder did not advance divisor");

    a_trivial_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST && i_status.trivial) |=> (r_state == S_DONE && !o_in_ready))
        else $error("trivial candidate not resolved at once");

endmodule

// ----- design/trial_division_primality_test_top.sv -----
// Top level of the trial division primality test.
//
// Input channel: i_valid / o_ready carry one item, i_candidate (31-bit unsigned).
// Output channel: o_valid / i_ready carry one item, o_is_prime, per input item.
// Zero and one give 0, two gives 1, other even numbers give 0 without division.
// Odd candidates are tried against odd divisors 3, 5, 7 ... while d*d <= n;
// the square is tracked incrementally, no multiplier.
// Each divisor takes one bound test plus a restoring remainder pass over the
// 31 candidate bits, one candidate bit per cycle. The worst case is 2^31-1,
// which is tried against 23169 divisors.
// One item is worked on at a time; o_ready is high only when idle, which is
// again from the cycle in which o_valid rises.
// The result sits in an output register, so a new item is taken while the
// previous result still waits; if the receiver stalls, the finished verdict
// is held internally until the output register frees.
// Reset (i_rst_n low, synchronous) drops any item in flight, clears o_valid
// and holds o_ready low.
module trial_division_primality_test_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tdpt_pkg::VALUE_BITS-1:0] i_candidate,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_is_prime
);

    tdpt_pkg::t_cmd    cmd;
    tdpt_pkg::t_status status;

    tdpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tdpt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_candidate (i_candidate),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_is_prime  (o_is_prime)
    );

endmodule
